/* hdl/b64_pkg.sv */
`default_nettype none

package b64_pkg;

  // Width of the saturating per-buffer byte counter
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned BURST_DEPTH    = 4;

  localparam logic [7:0] CHAR_PAD   = 8'd61;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_PAD = 2'd1,
    STAT_SYM = 2'd2,
    STAT_END = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PAD_NONE   = 2'd0,
    PAD_THIRD  = 2'd1,
    PAD_FOURTH = 2'd2
  } pad_e;

  typedef struct packed {
    logic        valid;
    logic [5:0]  value;
  } sym_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    status_e     status;
    logic [15:0] byte_count;
    logic        run_last;
  } result_t;

  // All results caused by one input character
  typedef struct packed {
    logic [2:0]                  num;
    result_t [BURST_DEPTH-1:0]   ent;
  } burst_t;

  function automatic sym_t symbol_lookup(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'd65 && c <= 8'd90) begin
      s.value = 6'(c - 8'd65);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.value = 6'(c - 8'd71);
    end else if (c >= 8'd48 && c <= 8'd57) begin
      s.value = 6'(c + 8'd4);
    end else if (c == 8'd43) begin
      s.value = 6'd62;
    end else if (c == 8'd47) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

/* hdl/b64_decode.sv */
`default_nettype none

module b64_decode import b64_pkg::*; #(
  parameter int unsigned CountBits = COUNT_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_i,
  input  wire logic       last_i,
  output burst_t          burst_o
);

  logic [23:0]          gb_q, gb_d;
  logic [1:0]           pos_q, pos_d;
  pad_e                 pad_q, pad_d;
  logic                 failed_q, failed_d;
  logic [CountBits-1:0] prod_q, prod_d;

  function automatic logic [15:0] cnt16(input logic [CountBits-1:0] p);
    logic [CountBits+15:0] e;
    e = {16'd0, p};
    return e[15:0];
  endfunction

  function automatic logic [CountBits-1:0] sat_inc(input logic [CountBits-1:0] p);
    return (&p) ? p : p + CountBits'(1);
  endfunction

  logic                 is_space, is_pad, has_err;
  status_e              err_code;
  sym_t                 sym;
  logic [5:0]           sym_val;
  logic [23:0]          gb_shift;
  logic [CountBits-1:0] p1, p2, p3;
  burst_t               burst;

  assign sym      = symbol_lookup(char_i);
  assign is_space = (char_i == CHAR_SPACE) || (char_i == CHAR_TAB) ||
                    (char_i == CHAR_LF) || (char_i == CHAR_CR);
  assign is_pad   = (char_i == CHAR_PAD);
  assign sym_val  = is_pad ? 6'd0 : sym.value;
  assign gb_shift = {gb_q[17:0], sym_val};
  assign p1       = sat_inc(prod_q);
  assign p2       = sat_inc(p1);
  assign p3       = sat_inc(p2);

  always_comb begin
    gb_d     = gb_q;
    pos_d    = pos_q;
    pad_d    = pad_q;
    failed_d = failed_q;
    prod_d   = prod_q;
    has_err  = 1'b0;
    err_code = STAT_OK;
    burst    = '0;

    // Classify a pad: first pad at position 2 or 3 fixes the mode
    if (is_pad) begin
      if (pad_q == PAD_NONE) begin
        if (pos_q == 2'd2) begin
          pad_d = PAD_THIRD;
        end else if (pos_q == 2'd3) begin
          pad_d = PAD_FOURTH;
        end else begin
          has_err  = 1'b1;
          err_code = STAT_PAD;
        end
      end
    end else if (!sym.valid) begin
      has_err  = 1'b1;
      err_code = STAT_SYM;
    end

    if (!failed_q) begin
      if (!is_space) begin
        if (has_err) begin
          burst.ent[0].kind       = KIND_STATUS;
          burst.ent[0].status     = err_code;
          burst.ent[0].byte_count = cnt16(prod_q);
          burst.num               = 3'd1;
          failed_d                = 1'b1;
          pad_d                   = pad_q;
        end else if (pos_q == 2'd3) begin
          // Group complete: release one to three bytes
          burst.ent[0].kind       = KIND_DATA;
          burst.ent[0].data_byte  = gb_shift[23:16];
          burst.ent[0].byte_count = cnt16(p1);
          burst.num               = 3'd1;
          prod_d                  = p1;
          if (pad_d != PAD_THIRD) begin
            burst.ent[1].kind       = KIND_DATA;
            burst.ent[1].data_byte  = gb_shift[15:8];
            burst.ent[1].byte_count = cnt16(p2);
            burst.num               = 3'd2;
            prod_d                  = p2;
          end
          if (pad_d == PAD_NONE) begin
            burst.ent[2].kind       = KIND_DATA;
            burst.ent[2].data_byte  = gb_shift[7:0];
            burst.ent[2].byte_count = cnt16(p3);
            burst.num               = 3'd3;
            prod_d                  = p3;
          end
          gb_d  = '0;
          pos_d = 2'd0;
        end else begin
          gb_d  = gb_shift;
          pos_d = pos_q + 2'd1;
        end
      end else begin
        pad_d = pad_q;
      end
      if (last_i && !failed_d) begin
        burst.ent[burst.num[1:0]].kind       = KIND_STATUS;
        burst.ent[burst.num[1:0]].status     = (pos_d != 2'd0) ? STAT_END : STAT_OK;
        burst.ent[burst.num[1:0]].byte_count = cnt16(prod_d);
        burst.num                            = burst.num + 3'd1;
      end
    end else begin
      pad_d = pad_q;
    end

    for (int i = 0; i < BURST_DEPTH; i++) begin
      burst.ent[i].run_last = (burst.num != 3'd0) && (3'(i) == burst.num - 3'd1);
    end

    // End of buffer: drop all state for the next one
    if (last_i) begin
      gb_d     = '0;
      pos_d    = 2'd0;
      pad_d    = PAD_NONE;
      failed_d = 1'b0;
      prod_d   = '0;
    end
  end

  assign burst_o = burst;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q     <= '0;
      pos_q    <= 2'd0;
      pad_q    <= PAD_NONE;
      failed_q <= 1'b0;
      prod_q   <= '0;
    end else if (accept_i) begin
      gb_q     <= gb_d;
      pos_q    <= pos_d;
      pad_q    <= pad_d;
      failed_q <= failed_d;
      prod_q   <= prod_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/b64_burst.sv */
`default_nettype none

module b64_burst import b64_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  burst_t    burst_i,
  output logic      ready_o,
  output logic      valid_o,
  input  wire logic take_i,
  output result_t   result_o
);

  result_t [BURST_DEPTH-1:0] ent_q;
  logic [2:0]                cnt_q, cnt_d;
  logic [1:0]                rd_q, rd_d;

  assign valid_o  = (cnt_q != 3'd0);
  assign result_o = ent_q[rd_q];
  // Free when empty or when the final beat leaves this cycle
  assign ready_o  = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && take_i);

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (load_i) begin
      cnt_d = burst_i.num;
      rd_d  = 2'd0;
    end else if (take_i && valid_o) begin
      cnt_d = cnt_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ent_q <= burst_i.ent;
    end
  end

endmodule

`default_nettype wire

/* hdl/base64_stream_decoder.sv */
// Latency: the first result of a character is registered and appears in the cycle after its input beat.
// Throughput: one character per cycle while each yields at most one result and the
//   output is not stalled; a character that yields more than one result (up to four)
//   holds the input while the single result port drains the burst register one beat a cycle, unless stalled.
// Reset: rst_ni is asynchronous, active low; it clears the group state, the byte
//   counter and the error flag, and empties the burst register.
`default_nettype none

module base64_stream_decoder import b64_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input characters
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // last_char
  // Decoded bytes and status
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                           // [25:10] byte_count, [31:26] zero
  output logic             m_axis_tuser,   // kind: 0 data byte, 1 status
  output logic             m_axis_tlast    // run_last
);

  logic    in_beat;
  logic    out_take;
  burst_t  burst;
  result_t result;

  // A character is taken whenever the burst register can accept its results
  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // Character classification, group assembly and per-buffer state
  b64_decode #(
    .CountBits (COUNT_BITS)
  ) u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_beat),
    .char_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .burst_o  (burst)
  );

  // Hold the results of one character and advance them one beat at a time
  b64_burst u_burst (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (in_beat),
    .burst_i  (burst),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .take_i   (out_take),
    .result_o (result)
  );

  assign m_axis_tdata = {6'd0, result.byte_count, result.status, result.data_byte};
  assign m_axis_tuser = result.kind;
  assign m_axis_tlast = result.run_last;

endmodule

`default_nettype wire

/* hdl/b64_checker.sv */
`default_nettype none

module b64_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // Status always closes the results of its character
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
    else $error("status beat not last or carries data");

  // Data beats carry no status code
  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[9:8] == 2'd0))
    else $error("data beat with status code");

  // The rest of a burst follows without a gap; a new character enters only
  // alongside the final beat
  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tlast || !s_axis_tready))
    else $error("burst broken");

endmodule

bind base64_stream_decoder b64_checker u_b64_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
